@@ rtl/slfp_pkg.sv @@
package slfp_pkg;

  // framing bytes
  localparam logic [7:0] FRAME_END = 8'hC0;
  localparam logic [7:0] FRAME_ESC = 8'hDB;
  localparam logic [7:0] ESC_END   = 8'hDC;
  localparam logic [7:0] ESC_ESC   = 8'hDD;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] TYPE_NINE = 8'h39;

  // frame positions and length thresholds
  localparam int STORE_BYTES = 34;
  localparam int LEN_MIN     = 2;
  localparam int LEN_CORE    = 20;
  localparam int LEN_MAG     = 26;
  localparam int LEN_BATT    = 28;
  localparam int LEN_TEMP    = 30;
  localparam int LEN_PRESS   = 34;

  localparam logic [15:0] THRESHOLD_RESET = 16'd3500;

  localparam int OUT_DATA_W = 272;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_SHORT    = 2'd2
  } slfp_status_t;

  // one completed frame, classified by the front end
  typedef struct packed {
    logic                 is_nine;
    logic                 ge_min;
    logic                 ge_core;
    logic                 ge_mag;
    logic                 ge_batt;
    logic                 ge_temp;
    logic                 ge_press;
    logic [STORE_BYTES-1:1][7:0] bytes;
  } slfp_frame_t;

endpackage

@@ rtl/slfp_front.sv @@
module slfp_front #(
  parameter int FRAME_LIMIT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  logic                 q_ready,
  output logic                 q_push,
  output slfp_pkg::slfp_frame_t q_frame
);
  import slfp_pkg::*;

  localparam int LW = $clog2(FRAME_LIMIT + 1);
  localparam logic [LW-1:0] LIM_SLIP = LW'(FRAME_LIMIT);
  localparam logic [LW-1:0] LIM_LINE = LW'(FRAME_LIMIT - 1);

  logic          slip_r, slip_nxt;
  logic          esc_r, esc_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    first_r;
  logic [STORE_BYTES-1:1][7:0] buf_r;

  logic          acc;
  logic          term;
  logic          do_app;
  logic          wr;
  logic [7:0]    app_byte;
  logic [LW-1:0] limit;

  assign in_tready = q_ready;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    slip_nxt = slip_r;
    esc_nxt  = esc_r;
    len_nxt  = len_r;
    term     = 1'b0;
    do_app   = 1'b0;
    app_byte = in_tdata;
    limit    = slip_r ? LIM_SLIP : LIM_LINE;
    if (acc) begin
      if (!slip_r) begin
        if (in_tdata == FRAME_END) begin
          len_nxt  = '0;
          esc_nxt  = 1'b0;
          slip_nxt = 1'b1;
        end else if (in_tdata == CHAR_CR || in_tdata == CHAR_LF) begin
          if (len_r != '0) begin
            term    = 1'b1;
            len_nxt = '0;
          end
        end else begin
          do_app = 1'b1;
        end
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        do_app  = 1'b1;
        if (in_tdata == ESC_END) begin
          app_byte = FRAME_END;
        end else if (in_tdata == ESC_ESC) begin
          app_byte = FRAME_ESC;
        end
      end else if (in_tdata == FRAME_END) begin
        if (len_r != '0) begin
          term     = 1'b1;
          len_nxt  = '0;
          slip_nxt = 1'b0;
        end
      end else if (in_tdata == FRAME_ESC) begin
        esc_nxt = 1'b1;
      end else begin
        do_app = 1'b1;
      end
    end
    wr = do_app && (len_r < limit);
    if (wr) begin
      len_nxt = len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slip_r <= 1'b0;
      esc_r  <= 1'b0;
      len_r  <= '0;
    end else begin
      slip_r <= slip_nxt;
      esc_r  <= esc_nxt;
      len_r  <= len_nxt;
    end
  end

  // frame bytes past the stored window are dropped
  always_ff @(posedge clk) begin
    if (wr) begin
      if (len_r == '0) begin
        first_r <= app_byte;
      end
      for (int i = 1; i < STORE_BYTES; i++) begin
        if (len_r == LW'(i)) begin
          buf_r[i] <= app_byte;
        end
      end
    end
  end

  assign q_push = term;

  always_comb begin
    q_frame.is_nine  = (first_r == TYPE_NINE);
    q_frame.ge_min   = (len_r >= LW'(LEN_MIN));
    q_frame.ge_core  = (len_r >= LW'(LEN_CORE));
    q_frame.ge_mag   = (len_r >= LW'(LEN_MAG));
    q_frame.ge_batt  = (len_r >= LW'(LEN_BATT));
    q_frame.ge_temp  = (len_r >= LW'(LEN_TEMP));
    q_frame.ge_press = (len_r >= LW'(LEN_PRESS));
    q_frame.bytes    = buf_r;
  end

  a_esc_in_slip: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> slip_r)
    else $error("escape pending outside SLIP mode");

  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LIM_SLIP && (slip_r || len_r <= LIM_LINE))
    else $error("frame length past its limit");

endmodule

@@ rtl/slfp_queue.sv @@
module slfp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  slfp_pkg::slfp_frame_t push_frame,
  output logic                  push_ready,
  output logic                  pop_valid,
  input  logic                  pop,
  output slfp_pkg::slfp_frame_t pop_frame
);
  import slfp_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  slfp_frame_t   mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_pop     = pop && pop_valid;
  assign pop_frame  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_frame;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("frame pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count past depth");

endmodule

@@ rtl/slfp_back.sv @@
module slfp_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  slfp_pkg::slfp_frame_t                q_frame,
  output logic                                 q_pop,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [15:0]                          cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [slfp_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [slfp_pkg::OUT_USER_W-1:0]      out_tuser
);
  import slfp_pkg::*;

  localparam int PAD_W = OUT_DATA_W - 265;

  logic [15:0] thr_r;
  logic [15:0] batt_r, batt_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [31:0] press_r, press_nxt;
  logic        low_r, low_nxt;
  logic        valid_r;
  logic [OUT_DATA_W-1:0] data_r;
  slfp_status_t status_r, status;
  logic        ok;
  logic [7:0]  version;
  logic [15:0] sample;
  logic [31:0] stamp;
  logic [47:0] accel, gyro, mag;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_valid && (!valid_r || out_tready);

  always_comb begin
    ok = q_frame.is_nine && q_frame.ge_min && q_frame.ge_core;
    if (!q_frame.is_nine || !q_frame.ge_min) begin
      status = ST_BAD_TYPE;
    end else if (!q_frame.ge_core) begin
      status = ST_SHORT;
    end else begin
      status = ST_OK;
    end
    version = ok ? q_frame.bytes[1] : '0;
    sample  = ok ? q_frame.bytes[3:2] : '0;
    stamp   = ok ? q_frame.bytes[7:4] : '0;
    accel   = ok ? q_frame.bytes[13:8] : '0;
    gyro    = ok ? q_frame.bytes[19:14] : '0;
    mag     = (ok && q_frame.ge_mag) ? q_frame.bytes[25:20] : '0;

    batt_nxt  = batt_r;
    low_nxt   = low_r;
    temp_nxt  = temp_r;
    press_nxt = press_r;
    // latch only the optional fields that the frame carries
    if (ok && q_frame.ge_batt) begin
      batt_nxt = q_frame.bytes[27:26];
      low_nxt  = (q_frame.bytes[27:26] < thr_r);
    end
    if (ok && q_frame.ge_temp) begin
      temp_nxt = q_frame.bytes[29:28];
    end
    if (ok && q_frame.ge_press) begin
      press_nxt = q_frame.bytes[33:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      batt_r  <= 16'hFFFF;
      temp_r  <= 16'hFFFF;
      press_r <= 32'hFFFF_FFFF;
      low_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (q_pop) begin
        batt_r  <= batt_nxt;
        temp_r  <= temp_nxt;
        press_r <= press_nxt;
        low_r   <= low_nxt;
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status;
      data_r   <= {{PAD_W{1'b0}}, low_nxt, press_nxt, temp_nxt, batt_nxt,
                   mag, gyro, accel, stamp, sample, version};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = status_r;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (status_r == ST_OK || status_r == ST_BAD_TYPE || status_r == ST_SHORT))
    else $error("undefined frame status on the output");

  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r != ST_OK) |-> (data_r[199:0] == '0))
    else $error("sensor fields not cleared on a rejected frame");

endmodule

@@ rtl/slip_line_sensor_frame_parser_top.sv @@
// Byte-stream frame parser for a motion sensor link. One received byte is
// accepted per cycle on in_* while in_tready is high, in line mode (CR/LF
// terminated) or SLIP mode (entered on 0xC0, left at the closing 0xC0). Each
// non-empty frame gives one transfer on out_* carrying its status in out_tuser
// and the decoded sensor words plus the latched battery, temperature, pressure
// and low-battery flag in out_tdata. The front end takes a byte every cycle
// while in_tready is high; a finished frame is written into a two-entry queue
// and from there into the output register, which drives out_tvalid. in_tready
// drops only while both queue entries hold frames that the output side has not
// yet taken. cfg_* writes the low-battery threshold (millivolts, reset 3500);
// it is always ready and is meant to be written while no frame is in flight.
module slip_line_sensor_frame_parser_top #(
  parameter int FRAME_LIMIT = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] packet_version, [23:8] sample_number, [55:24] time_stamp,
  // [103:56] accel_xyz, [151:104] gyro_xyz, [199:152] mag_xyz,
  // [215:200] battery_latched, [231:216] temperature_latched,
  // [263:232] pressure_latched, [264] battery_low, [271:265] zero
  output logic [slfp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [slfp_pkg::OUT_USER_W-1:0] out_tuser,  // [1:0] frame_status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [15:0]                     cfg_data     // battery_low_threshold
);
  import slfp_pkg::*;

  logic        q_ready;
  logic        q_push;
  slfp_frame_t q_in_frame;
  logic        q_valid;
  logic        q_pop;
  slfp_frame_t q_out_frame;

  slfp_front #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_frame   (q_in_frame)
  );

  slfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (q_in_frame),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_frame  (q_out_frame)
  );

  slfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_frame    (q_out_frame),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
